/* rtl/lfu_slot_replacement_core_defines.svh */
// ----------------------------------------------------------------------------
// LFU slot replacement assertion macros
// Shared property wrappers for the concurrent checks of the replacement core.
// ----------------------------------------------------------------------------
`ifndef LFU_SLOT_REPLACEMENT_CORE_DEFINES_SVH
`define LFU_SLOT_REPLACEMENT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFUSR_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFUSR_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/lfusr_pkg.sv */
// ----------------------------------------------------------------------------
// LFU slot replacement package
// Widths, codes and the structures passed along the slot cell chain.
// ----------------------------------------------------------------------------
package lfusr_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ID_W    = 16;
    localparam int USE_W   = 16;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [USE_W-1:0]   USE_MAX   = {USE_W{1'b1}};
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(SLOTS);

    // Search token that travels from cell to cell, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic               found;
        logic [SLOT_W-1:0]  match_idx;
        logic [USE_W-1:0]   match_uses;
        logic               has_empty;
        logic [SLOT_W-1:0]  empty_idx;
        logic [SLOT_W-1:0]  victim_idx;
        logic [ID_W-1:0]    victim_ident;
        logic [USE_W-1:0]   best_uses;
        logic [STAMP_W-1:0] best_stamp;
    } token_t;

    // Write command broadcast to all cells once the search has finished.
    typedef struct packed {
        logic               en;
        logic               miss;
        logic [SLOT_W-1:0]  idx;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } update_t;

endpackage

/* rtl/lfusr_cell.sv */
// ----------------------------------------------------------------------------
// LFU slot cell
// Holds one slot and folds it into the search token that passes through.
// ----------------------------------------------------------------------------
module lfusr_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lfusr_pkg::SLOT_W-1:0] cell_idx,
    input  logic                        active,
    input  lfusr_pkg::token_t           tok_in,
    input  lfusr_pkg::update_t          upd,
    output lfusr_pkg::token_t           tok_out
);

    logic [lfusr_pkg::ID_W-1:0]    ident_reg;
    logic [lfusr_pkg::USE_W-1:0]   uses_reg;
    logic [lfusr_pkg::STAMP_W-1:0] stamp_reg;
    lfusr_pkg::token_t             tok_reg;
    lfusr_pkg::token_t             tok_next;
    logic                          sel;

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && active)
        begin
            // The first matching slot wins; later matches are ignored.
            if (!tok_in.found && (ident_reg == tok_in.id))
            begin
                tok_next.found      = 1'b1;
                tok_next.match_idx  = cell_idx;
                tok_next.match_uses = uses_reg;
            end
            // The highest-numbered empty slot wins, so each one overrides.
            if (ident_reg == '0)
            begin
                tok_next.has_empty = 1'b1;
                tok_next.empty_idx = cell_idx;
            end
            if ((cell_idx == '0) || (uses_reg < tok_in.best_uses) ||
                ((uses_reg == tok_in.best_uses) && (stamp_reg < tok_in.best_stamp)))
            begin
                tok_next.victim_idx   = cell_idx;
                tok_next.victim_ident = ident_reg;
                tok_next.best_uses    = uses_reg;
                tok_next.best_stamp   = stamp_reg;
            end
        end
    end

    assign sel = upd.en && (upd.idx == cell_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg <= '0;
            uses_reg  <= '0;
            stamp_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (sel)
            begin
                if (upd.miss)
                begin
                    ident_reg <= upd.id;
                    uses_reg  <= lfusr_pkg::USE_W'(1);
                    stamp_reg <= upd.stamp;
                end
                else if (uses_reg != lfusr_pkg::USE_MAX)
                begin
                    uses_reg <= uses_reg + lfusr_pkg::USE_W'(1);
                end
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

/* rtl/lfu_slot_replacement_core.sv */
// ----------------------------------------------------------------------------
// LFU slot replacement core
// Least-frequently-used slot table with oldest-first, then lowest-index,
// tie breaking, built as a chain of slot cells searched by a moving token.
// ----------------------------------------------------------------------------
// Channel    Signals                                          Transfer when
// request    start, busy, candidate_id                        start && !busy
// result     done, hit, slot_index, evicted, evicted_id,      done
//            new_count
// config     active_slots_wr, active_slots                    active_slots_wr
//
// A nonzero identifier's token steps through all SLOTS cells, one cell per
// cycle; the result and the slot write command are then registered together
// and the slot is written in the commit state. A zero identifier gives its
// all-zero result in the cycle after the transfer. Reset is asynchronous and
// clears every slot. The one-cycle result strobe cannot be held off.
// ----------------------------------------------------------------------------
`include "lfu_slot_replacement_core_defines.svh"

module lfu_slot_replacement_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lfusr_pkg::ID_W-1:0]    candidate_id,
    input  logic                          active_slots_wr,
    input  logic [lfusr_pkg::CFG_W-1:0]   active_slots,
    output logic                          done,
    output logic                          hit,
    output logic [lfusr_pkg::SLOT_W-1:0]  slot_index,
    output logic                          evicted,
    output logic [lfusr_pkg::ID_W-1:0]    evicted_id,
    output logic [lfusr_pkg::USE_W-1:0]   new_count
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [lfusr_pkg::CFG_W-1:0]   cfg_reg;
    logic [lfusr_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    lfusr_pkg::update_t            upd_reg, upd_next;
    logic                          done_reg, done_next;
    logic                          hit_reg, hit_next;
    logic [lfusr_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic                          evicted_reg, evicted_next;
    logic [lfusr_pkg::ID_W-1:0]    evid_reg, evid_next;
    logic [lfusr_pkg::USE_W-1:0]   count_reg, count_next;

    lfusr_pkg::token_t             launch;
    lfusr_pkg::token_t             tok [lfusr_pkg::SLOTS];
    lfusr_pkg::token_t             last;
    logic [lfusr_pkg::SLOTS-1:0]   active_vec;
    logic [lfusr_pkg::SLOTS-1:0]   tok_valid;
    logic                          accept;
    logic [lfusr_pkg::SLOT_W-1:0]  target;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign last   = tok[lfusr_pkg::SLOTS-1];

    always_comb
    begin
        launch       = '0;
        launch.valid = accept && (candidate_id != '0);
        launch.id    = candidate_id;
    end

    genvar k;
    generate
        for (k = 0; k < lfusr_pkg::SLOTS; k++)
        begin : g_cell
            // Slot zero is always in use; a setting of zero acts as one.
            assign active_vec[k] = (k == 0) || (k < 32'(cfg_reg));
            assign tok_valid[k]  = tok[k].valid;
            if (k == 0)
            begin : g_head
                lfusr_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cell_idx (lfusr_pkg::SLOT_W'(k)),
                    .active   (active_vec[k]),
                    .tok_in   (launch),
                    .upd      (upd_reg),
                    .tok_out  (tok[k])
                );
            end
            else
            begin : g_body
                lfusr_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cell_idx (lfusr_pkg::SLOT_W'(k)),
                    .active   (active_vec[k]),
                    .tok_in   (tok[k-1]),
                    .upd      (upd_reg),
                    .tok_out  (tok[k])
                );
            end
        end
    endgenerate

    always_comb
    begin
        if (last.found)
        begin
            target = last.match_idx;
        end
        else if (last.has_empty)
        begin
            target = last.empty_idx;
        end
        else
        begin
            target = last.victim_idx;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        stamp_next   = stamp_reg;
        upd_next     = upd_reg;
        upd_next.en  = 1'b0;
        done_next    = 1'b0;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        evicted_next = evicted_reg;
        evid_next    = evid_reg;
        count_next   = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stamp_reg != lfusr_pkg::STAMP_MAX)
                    begin
                        stamp_next = stamp_reg + lfusr_pkg::STAMP_W'(1);
                    end
                    if (candidate_id == '0)
                    begin
                        done_next    = 1'b1;
                        hit_next     = 1'b0;
                        slot_next    = '0;
                        evicted_next = 1'b0;
                        evid_next    = '0;
                        count_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (last.valid)
                begin
                    done_next      = 1'b1;
                    hit_next       = last.found;
                    slot_next      = target;
                    evicted_next   = !last.found && !last.has_empty;
                    evid_next      = (!last.found && !last.has_empty) ?
                                     last.victim_ident : '0;
                    if (!last.found)
                    begin
                        count_next = lfusr_pkg::USE_W'(1);
                    end
                    else if (last.match_uses == lfusr_pkg::USE_MAX)
                    begin
                        count_next = lfusr_pkg::USE_MAX;
                    end
                    else
                    begin
                        count_next = last.match_uses + lfusr_pkg::USE_W'(1);
                    end
                    upd_next.en    = 1'b1;
                    upd_next.miss  = !last.found;
                    upd_next.idx   = target;
                    upd_next.id    = last.id;
                    upd_next.stamp = stamp_reg;
                    state_next     = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_reg   <= lfusr_pkg::CFG_RESET;
            stamp_reg <= '0;
            upd_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stamp_reg <= stamp_next;
            upd_reg   <= upd_next;
            done_reg  <= done_next;
            if (active_slots_wr)
            begin
                cfg_reg <= active_slots;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        evicted_reg <= evicted_next;
        evid_reg    <= evid_next;
        count_reg   <= count_next;
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign slot_index = slot_reg;
    assign evicted    = evicted_reg;
    assign evicted_id = evid_reg;
    assign new_count  = count_reg;

    // Only one search token may be in the chain at a time.
    `LFUSR_ASSERT_IMPLY(a_one_token, clk, rst_n, 1'b1, $onehot0(tok_valid),
        "more than one search token in the cell chain")
    // A replacement only happens when every active slot holds an identifier.
    `LFUSR_ASSERT_IMPLY(a_evict_nonzero, clk, rst_n, done && evicted, evicted_id != '0,
        "eviction reported an empty slot")
    // A finished search is always followed by the slot write cycle.
    `LFUSR_ASSERT_NEXT(a_commit_follows, clk, rst_n, state_reg == ST_SEARCH && last.valid,
        upd_reg.en && done_reg && busy,
        "slot write did not follow the search")

endmodule

/* tb/lfu_slot_replacement_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU slot replacement core testbench
// Sends identifiers through the command port and checks every result against
// a cycle-free model of the slot table. The run has two parts. A directed
// table covers empty slots, eviction, the active slot count and zero
// identifiers. Random phases then run under several slot counts.
// ----------------------------------------------------------------------------
module lfu_slot_replacement_core_tb;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 143;
    localparam int PRINT_LIMIT  = 50;

    typedef struct packed {
        logic                         hit;
        logic [lfusr_pkg::SLOT_W-1:0] slot_index;
        logic                         evicted;
        logic [lfusr_pkg::ID_W-1:0]   evicted_id;
        logic [lfusr_pkg::USE_W-1:0]  new_count;
    } lfu_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] data;
        logic        typed;
        lfu_result_t want;
    } row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [lfusr_pkg::ID_W-1:0]   candidate_id = '0;
    logic                         active_slots_wr = 1'b0;
    logic [lfusr_pkg::CFG_W-1:0]  active_slots = '0;
    logic                         done;
    logic                         hit;
    logic [lfusr_pkg::SLOT_W-1:0] slot_index;
    logic                         evicted;
    logic [lfusr_pkg::ID_W-1:0]   evicted_id;
    logic [lfusr_pkg::USE_W-1:0]  new_count;

    // Model of the slot table.
    logic [lfusr_pkg::ID_W-1:0]    held_id    [lfusr_pkg::SLOTS];
    logic [lfusr_pkg::USE_W-1:0]   use_count  [lfusr_pkg::SLOTS];
    logic [lfusr_pkg::STAMP_W-1:0] fill_stamp [lfusr_pkg::SLOTS];
    logic [lfusr_pkg::STAMP_W-1:0] stamp_now;
    logic [lfusr_pkg::CFG_W-1:0]   live_slots;

    lfu_result_t pending_results [$];
    row_t        plan [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;

    lfu_slot_replacement_core u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .candidate_id    (candidate_id),
        .active_slots_wr (active_slots_wr),
        .active_slots    (active_slots),
        .done            (done),
        .hit             (hit),
        .slot_index      (slot_index),
        .evicted         (evicted),
        .evicted_id      (evicted_id),
        .new_count       (new_count)
    );

    always #2 clk = ~clk;

    function automatic lfu_result_t predict_access(input logic [lfusr_pkg::ID_W-1:0] id);
        lfu_result_t                   r;
        int                            n;
        int                            k;
        int                            match_k;
        int                            empty_k;
        int                            victim_k;
        int                            target;
        bit                            found;
        bit                            has_empty;
        logic [lfusr_pkg::USE_W-1:0]   best_uses;
        logic [lfusr_pkg::STAMP_W-1:0] best_stamp;
        r = '0;
        found = 1'b0;
        has_empty = 1'b0;
        match_k = 0;
        empty_k = 0;
        victim_k = 0;
        best_uses = '0;
        best_stamp = '0;
        // The stamp advances for every item, ignored ones included.
        if (stamp_now != lfusr_pkg::STAMP_MAX)
            stamp_now = stamp_now + lfusr_pkg::STAMP_W'(1);
        if (id == '0)
            return r;
        n = int'(live_slots);
        if (n == 0)
            n = 1;
        if (n > lfusr_pkg::SLOTS)
            n = lfusr_pkg::SLOTS;
        for (k = 0; k < n; k++)
        begin
            if (!found && held_id[k] == id)
            begin
                found = 1'b1;
                match_k = k;
            end
            if (held_id[k] == '0)
            begin
                has_empty = 1'b1;
                empty_k = k;
            end
            if (k == 0 || use_count[k] < best_uses ||
                (use_count[k] == best_uses && fill_stamp[k] < best_stamp))
            begin
                victim_k = k;
                best_uses = use_count[k];
                best_stamp = fill_stamp[k];
            end
        end
        if (found)
        begin
            target = match_k;
            if (use_count[target] != lfusr_pkg::USE_MAX)
                use_count[target] = use_count[target] + lfusr_pkg::USE_W'(1);
            r.hit = 1'b1;
        end
        else
        begin
            target = has_empty ? empty_k : victim_k;
            if (!has_empty)
            begin
                r.evicted = 1'b1;
                r.evicted_id = held_id[target];
            end
            held_id[target] = id;
            use_count[target] = lfusr_pkg::USE_W'(1);
            fill_stamp[target] = stamp_now;
        end
        r.slot_index = lfusr_pkg::SLOT_W'(target);
        r.new_count = use_count[target];
        return r;
    endfunction

    function automatic row_t plan_row(input row_kind_t kind, input logic [15:0] data,
                                      input logic typed, input logic h,
                                      input logic [lfusr_pkg::SLOT_W-1:0] s,
                                      input logic e,
                                      input logic [lfusr_pkg::ID_W-1:0] eid,
                                      input logic [lfusr_pkg::USE_W-1:0] c);
        row_t r;
        r.kind = kind;
        r.data = data;
        r.typed = typed;
        r.want.hit = h;
        r.want.slot_index = s;
        r.want.evicted = e;
        r.want.evicted_id = eid;
        r.want.new_count = c;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns mismatch: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [lfusr_pkg::ID_W-1:0] id, input logic typed,
                             input lfu_result_t typed_res);
        lfu_result_t r;
        start <= 1'b1;
        candidate_id <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_access(id);
        pending_results.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int gap, input bit drain);
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            start <= 1'b0;
            candidate_id <= lfusr_pkg::ID_W'($urandom);
            repeat (gap)
                @(negedge clk);
            while (drain && pending_results.size() != 0)
                @(negedge clk);
        end
    endtask

    // Waits until every result has arrived and the slot write has finished.
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0 || busy);
        repeat (2)
            @(negedge clk);
    endtask

    task automatic write_active_slots(input logic [lfusr_pkg::CFG_W-1:0] value);
        wait_idle();
        active_slots_wr <= 1'b1;
        active_slots <= value;
        @(negedge clk);
        active_slots_wr <= 1'b0;
        live_slots = value;
    endtask

    always @(posedge clk)
    begin : result_check
        lfu_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing outstanding", 32'd0, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", 32'(hit), 32'(want.hit));
                if (slot_index !== want.slot_index)
                    report_mismatch("slot_index", 32'(slot_index), 32'(want.slot_index));
                if (evicted !== want.evicted)
                    report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
                if (evicted_id !== want.evicted_id)
                    report_mismatch("evicted_id", 32'(evicted_id), 32'(want.evicted_id));
                if (new_count !== want.new_count)
                    report_mismatch("new_count", 32'(new_count), 32'(want.new_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [lfusr_pkg::ID_W-1:0]  id_pool [0:19];
        logic [lfusr_pkg::ID_W-1:0]  id;
        int                          pool_size;
        int                          pick;
        int                          row_n;
        int                          phase;
        int                          item_n;
        bit                          no_gaps;
        logic [lfusr_pkg::CFG_W-1:0] slots_cfg;

        for (int k = 0; k < lfusr_pkg::SLOTS; k++)
        begin
            held_id[k] = '0;
            use_count[k] = '0;
            fill_stamp[k] = '0;
        end
        stamp_now = '0;
        live_slots = lfusr_pkg::CFG_RESET;

        // Rows with a typed result can be read straight off the rules.
        plan.push_back(plan_row(ROW_ITEM, 16'h0000, 1'b1, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'hFFFF, 1'b1, 1'b0, 4'd15, 1'b0, 16'h0000, 16'd1));
        plan.push_back(plan_row(ROW_ITEM, 16'hFFFF, 1'b1, 1'b1, 4'd15, 1'b0, 16'h0000, 16'd2));
        plan.push_back(plan_row(ROW_ITEM, 16'h0001, 1'b1, 1'b0, 4'd14, 1'b0, 16'h0000, 16'd1));
        plan.push_back(plan_row(ROW_CFG,  16'd1,    1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'hFFFF, 1'b1, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd1));
        plan.push_back(plan_row(ROW_ITEM, 16'h00AA, 1'b1, 1'b0, 4'd0, 1'b1, 16'hFFFF, 16'd1));
        plan.push_back(plan_row(ROW_ITEM, 16'h00AA, 1'b1, 1'b1, 4'd0, 1'b0, 16'h0000, 16'd2));
        plan.push_back(plan_row(ROW_CFG,  16'd0,    1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'h5555, 1'b1, 1'b0, 4'd0, 1'b1, 16'h00AA, 16'd1));
        plan.push_back(plan_row(ROW_CFG,  16'd31,   1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'hFFFF, 1'b1, 1'b1, 4'd15, 1'b0, 16'h0000, 16'd3));
        plan.push_back(plan_row(ROW_ITEM, 16'h0001, 1'b1, 1'b1, 4'd14, 1'b0, 16'h0000, 16'd2));
        plan.push_back(plan_row(ROW_ITEM, 16'h1234, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_CFG,  16'd3,    1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'h0002, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'h0003, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'h0004, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'h0003, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'h0005, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_ITEM, 16'h0000, 1'b1, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));
        plan.push_back(plan_row(ROW_CFG,  16'd16,   1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0));

        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (row_n = 0; row_n < plan.size(); row_n++)
        begin
            if (plan[row_n].kind == ROW_CFG)
                write_active_slots(plan[row_n].data[lfusr_pkg::CFG_W-1:0]);
            else
            begin
                send_item(plan[row_n].data, plan[row_n].typed, plan[row_n].want);
                pause_sender($urandom_range(0, 3), 1'b0);
            end
        end

        // Random phases: a small pool of identifiers, a few of them hot, so
        // that hits, fills and evictions all happen under each slot count.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       slots_cfg = 5'd16;
                1:       slots_cfg = 5'd1;
                2:       slots_cfg = 5'd31;
                3:       slots_cfg = 5'd0;
                default: slots_cfg = lfusr_pkg::CFG_W'($urandom_range(0, 31));
            endcase
            write_active_slots(slots_cfg);
            pool_size = $urandom_range(2, 20);
            for (int k = 0; k < 20; k++)
                id_pool[k] = lfusr_pkg::ID_W'($urandom_range(1, 65535));
            no_gaps = ($urandom_range(0, 3) == 0);
            for (item_n = 0; item_n < PHASE_ITEMS; item_n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    id = id_pool[$urandom_range(0, 1)];
                else if (pick < 85)
                    id = id_pool[$urandom_range(0, pool_size - 1)];
                else if (pick < 95)
                    id = lfusr_pkg::ID_W'($urandom);
                else
                    id = '0;
                send_item(id, 1'b0, '0);
                if (item_n == PHASE_ITEMS / 2 || $urandom_range(0, 49) == 0)
                    pause_sender($urandom_range(0, 3), 1'b1);
                else if (!no_gaps)
                    pause_sender($urandom_range(0, 3), 1'b0);
            end
        end

        wait_idle();
        repeat (20)
            @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results still outstanding", 32'(pending_results.size()), 32'd0);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
